>>> hw/rtl/plpc_pkg.sv
`default_nettype none

package plpc_pkg;

  // Field and register widths
  localparam int unsigned PosW      = 15;
  localparam int unsigned AxisW     = 11;
  localparam int unsigned ArmW      = 12;
  localparam int unsigned DeadzoneW = 10;
  localparam int unsigned StepW     = 10;
  localparam int unsigned CfgDataW  = 15;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned ProdW     = AxisW + StepW;
  localparam int unsigned IncW      = 11;
  localparam int unsigned SumW      = PosW + 2;

  localparam int unsigned ValveHoldTicksDef = 10;

  // Register reset values
  localparam logic [DeadzoneW-1:0] DeadzoneReset = DeadzoneW'(100);
  localparam logic [ArmW-1:0]      ArmLimitReset = ArmW'(2048);
  localparam logic [StepW-1:0]     StepReset     = StepW'(150);
  localparam logic [PosW-1:0]      TopReset      = PosW'(24000);
  localparam logic [PosW-1:0]      HeightReset   = PosW'(4000);

  // x / 1000 == (x / 8) / 125; 268436 = ceil(2^25 / 125), exact for any 18-bit quotient of x / 8
  localparam int unsigned RecipW     = 19;
  localparam int unsigned RecipShift = 25;
  localparam logic [RecipW-1:0] Recip125 = RecipW'(268436);
  localparam int unsigned RecipProdW = (ProdW - 3) + RecipW;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2,
    DIR_INIT = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    VALVE_OFF = 2'd0,
    VALVE_FWD = 2'd1,
    VALVE_REV = 2'd2
  } valve_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEADZONE  = 2'd0,
    CFG_ARM_LIMIT = 2'd1,
    CFG_STEP      = 2'd2,
    CFG_TOP       = 2'd3
  } cfg_idx_e;

  // Controller state carried from tick to tick
  typedef struct packed {
    logic [PosW-1:0] est;
    logic [PosW-1:0] target;
    dir_e            dir;
    logic            latch;
    valve_e          lift;
    valve_e          supply;
  } plpc_state_t;

  // Pre-digested input item held in the input register
  typedef struct packed {
    logic             neg;
    logic             nudge;
    logic [ProdW-1:0] prod;
    logic             up;
    logic             dn;
    logic             arm_clear;
  } plpc_item_t;

  localparam plpc_state_t StateReset = '{
    est:    HeightReset,
    target: '0,
    dir:    DIR_INIT,
    latch:  1'b0,
    lift:   VALVE_OFF,
    supply: VALVE_OFF
  };

  function automatic logic [IncW-1:0] div1000(input logic [ProdW-1:0] x);
    logic [RecipProdW-1:0] p;
    p = RecipProdW'(x[ProdW-1:3]) * RecipProdW'(Recip125);
    return p[RecipShift +: IncW];
  endfunction

  function automatic logic [PosW-1:0] clamp_level(input logic signed [SumW-1:0] v,
                                                  input logic [PosW-1:0] top);
    logic signed [SumW-1:0] top_s;
    top_s = signed'(SumW'(top));
    if (v > top_s) begin
      return top;
    end else if (v < 0) begin
      return '0;
    end
    return v[PosW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/plpc_step.sv
`default_nettype none

module plpc_step #(
  parameter int unsigned TimerW    = 5,
  parameter int unsigned HoldTicks = plpc_pkg::ValveHoldTicksDef
) (
  input  plpc_pkg::plpc_state_t           state_i,
  input  logic signed [TimerW-1:0]        timer_i,
  input  plpc_pkg::plpc_item_t            item_i,
  input  logic [plpc_pkg::StepW-1:0]      step_i,
  input  logic [plpc_pkg::PosW-1:0]       top_i,
  output plpc_pkg::plpc_state_t           state_o,
  output logic signed [TimerW-1:0]        timer_o
);

  localparam logic signed [TimerW-1:0] Reload = TimerW'(HoldTicks);

  always_comb begin
    plpc_pkg::plpc_state_t             s;
    logic signed [TimerW-1:0]          tmr;
    logic signed [plpc_pkg::SumW-1:0]  step_s;
    logic signed [plpc_pkg::SumW-1:0]  mv;
    logic signed [plpc_pkg::SumW-1:0]  est_sum;
    logic signed [plpc_pkg::SumW-1:0]  tgt_sum;
    logic signed [plpc_pkg::SumW-1:0]  inc_s;
    logic signed [plpc_pkg::SumW-1:0]  rise;
    logic signed [plpc_pkg::SumW-1:0]  fall;
    logic [plpc_pkg::PosW-1:0]         gap;
    logic [plpc_pkg::IncW-1:0]         inc;
    logic                              latch;

    s       = state_i;
    tmr     = timer_i;
    step_s  = signed'(plpc_pkg::SumW'(step_i));
    mv      = '0;
    tgt_sum = '0;
    inc     = '0;
    inc_s   = '0;
    gap     = '0;
    latch   = state_i.latch;

    // Valve hold runs out: drop supply, count down to the saturating floor
    if (tmr[TimerW-1]) begin
      s.supply = plpc_pkg::VALVE_OFF;
    end else begin
      tmr = tmr - TimerW'(1);
    end

    // Dead reckoning
    unique case (s.dir)
      plpc_pkg::DIR_UP:   mv = step_s;
      plpc_pkg::DIR_DOWN: mv = -step_s;
      plpc_pkg::DIR_INIT: mv = -(step_s <<< 1);
      plpc_pkg::DIR_HOLD: mv = '0;
    endcase
    est_sum = signed'(plpc_pkg::SumW'(s.est)) + mv;
    s.est   = plpc_pkg::clamp_level(est_sum, top_i);

    if (s.dir == plpc_pkg::DIR_INIT) begin
      gap = (s.est >= s.target) ? s.est - s.target : s.target - s.est;
      if (plpc_pkg::SumW'(gap) < plpc_pkg::SumW'({step_i, 1'b0})) begin
        s.dir    = plpc_pkg::DIR_HOLD;
        s.lift   = plpc_pkg::VALVE_OFF;
        s.supply = plpc_pkg::VALVE_REV;
        tmr      = Reload;
      end
    end else begin
      if (item_i.nudge) begin
        inc     = plpc_pkg::div1000(item_i.prod);
        inc_s   = signed'(plpc_pkg::SumW'(inc));
        tgt_sum = signed'(plpc_pkg::SumW'(s.target)) + (item_i.neg ? -inc_s : inc_s);
        s.target = plpc_pkg::clamp_level(tgt_sum, top_i);
      end
      if (item_i.up && !latch) begin
        latch    = 1'b1;
        s.target = (s.dir == plpc_pkg::DIR_DOWN) ? s.est : top_i;
      end
      if (item_i.dn && !latch) begin
        latch    = 1'b1;
        s.target = (s.dir == plpc_pkg::DIR_UP) ? s.est : '0;
      end else begin
        latch = item_i.up || item_i.dn;
      end
      s.latch = latch;
    end

    rise = signed'(plpc_pkg::SumW'(s.target)) - signed'(plpc_pkg::SumW'(s.est));
    fall = -rise;

    if (rise > step_s) begin
      s.lift   = plpc_pkg::VALVE_FWD;
      s.dir    = plpc_pkg::DIR_UP;
      s.supply = plpc_pkg::VALVE_FWD;
      tmr      = Reload;
    end else if (fall > step_s) begin
      if (item_i.arm_clear) begin
        s.lift   = plpc_pkg::VALVE_REV;
        s.dir    = plpc_pkg::DIR_DOWN;
        s.supply = plpc_pkg::VALVE_FWD;
        tmr      = Reload;
      end else begin
        // Arms spread: block descent
        s.lift = plpc_pkg::VALVE_OFF;
        if (s.dir != plpc_pkg::DIR_HOLD) begin
          s.supply = plpc_pkg::VALVE_REV;
          tmr      = Reload;
        end
        s.dir = plpc_pkg::DIR_HOLD;
      end
    end else begin
      s.lift = plpc_pkg::VALVE_OFF;
      if (s.dir != plpc_pkg::DIR_HOLD) begin
        s.supply = plpc_pkg::VALVE_REV;
      end
      s.dir = plpc_pkg::DIR_HOLD;
    end

    state_o = s;
    timer_o = tmr;
  end

endmodule

`default_nettype wire

>>> hw/rtl/pneumatic_lift_position_controller_unit.sv
// An accepted item is held in the input register, then in the result register (the state registers).
// Throughput: one item per cycle while out_stall_i is low; the tick update is a single pass of clamp,
// compare and one constant-reciprocal multiply between the input register and the state registers.
// Reset (rst_ni low, asynchronous) loads the register defaults, height 4000, goal 0,
// motion initialising, valves off, valve timer 0, and empties both stages.
`default_nettype none

module pneumatic_lift_position_controller_unit #(
  parameter int unsigned ValveHoldTicks = plpc_pkg::ValveHoldTicksDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [plpc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [plpc_pkg::CfgDataW-1:0]       cfg_data_i,

  // Input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [plpc_pkg::AxisW-1:0]   axis_i,
  input  logic                                up_button_i,
  input  logic                                down_button_i,
  input  logic [plpc_pkg::ArmW-1:0]           left_arm_position_i,
  input  logic [plpc_pkg::ArmW-1:0]           right_arm_position_i,

  // Result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          lift_valve_o,
  output logic [1:0]                          supply_valve_o,
  output logic [plpc_pkg::PosW-1:0]           height_o,
  output logic [plpc_pkg::PosW-1:0]           goal_o,
  output logic [1:0]                          motion_o
);

  // Signed timer wide enough for the hold count and the -1 floor
  localparam int unsigned TimerW = $clog2(ValveHoldTicks + 1) + 1;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [plpc_pkg::DeadzoneW-1:0] deadzone_q;
  logic [plpc_pkg::ArmW-1:0]      arm_limit_q;
  logic [plpc_pkg::StepW-1:0]     step_q;
  logic [plpc_pkg::PosW-1:0]      top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q  <= plpc_pkg::DeadzoneReset;
      arm_limit_q <= plpc_pkg::ArmLimitReset;
      step_q      <= plpc_pkg::StepReset;
      top_q       <= plpc_pkg::TopReset;
    end else if (cfg_we_i) begin
      unique case (plpc_pkg::cfg_idx_e'(cfg_index_i))
        plpc_pkg::CFG_DEADZONE:  deadzone_q  <= cfg_data_i[plpc_pkg::DeadzoneW-1:0];
        plpc_pkg::CFG_ARM_LIMIT: arm_limit_q <= cfg_data_i[plpc_pkg::ArmW-1:0];
        plpc_pkg::CFG_STEP:      step_q      <= cfg_data_i[plpc_pkg::StepW-1:0];
        plpc_pkg::CFG_TOP:       top_q       <= cfg_data_i[plpc_pkg::PosW-1:0];
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Handshake. The state registers double as the result register, so a
  // tick may only run when the previous result has gone or goes now.
  // ------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic adv;
  logic in_accept;

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // ------------------------------------------------------------------
  // Input stage: fold the item against the registers. The axis product
  // is formed here so that the divide-by-1000 multiply sits after a
  // register. The user must keep the registers steady while any item is
  // in flight; the block itself does not enforce it.
  logic [plpc_pkg::AxisW-1:0] axis_mag;
  plpc_pkg::plpc_item_t       item_d, s1_item_q;

  assign axis_mag = axis_i[plpc_pkg::AxisW-1] ? (~axis_i + 1'b1) : axis_i;

  always_comb begin
    item_d.neg       = axis_i[plpc_pkg::AxisW-1];
    item_d.nudge     = axis_mag > plpc_pkg::AxisW'(deadzone_q);
    item_d.prod      = plpc_pkg::ProdW'(axis_mag) * plpc_pkg::ProdW'(step_q);
    item_d.up        = up_button_i;
    item_d.dn        = down_button_i;
    item_d.arm_clear = (left_arm_position_i <= arm_limit_q) &&
                       (right_arm_position_i <= arm_limit_q);
  end

  // Payload only: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= item_d;
    end
  end

  // ------------------------------------------------------------------
  // Tick: controller state and valve timer
  // ------------------------------------------------------------------
  plpc_pkg::plpc_state_t     state_q, state_d;
  logic signed [TimerW-1:0]  timer_q, timer_d;

  plpc_step #(
    .TimerW    (TimerW),
    .HoldTicks (ValveHoldTicks)
  ) u_step (
    .state_i (state_q),
    .timer_i (timer_q),
    .item_i  (s1_item_q),
    .step_i  (step_q),
    .top_i   (top_q),
    .state_o (state_d),
    .timer_o (timer_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plpc_pkg::StateReset;
      timer_q <= '0;
    end else if (adv) begin
      state_q <= state_d;
      timer_q <= timer_d;
    end
  end

  // The result is the state after the tick
  assign lift_valve_o   = state_q.lift;
  assign supply_valve_o = state_q.supply;
  assign height_o       = state_q.est;
  assign goal_o         = state_q.target;
  assign motion_o       = state_q.dir;

`ifndef NO_ASSERTIONS
  // No tick leaves the lift in start-up mode
  a_no_init_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motion_o != plpc_pkg::DIR_INIT))
    else $error("motion still initialising after a tick");

  // A moving lift always has supply open
  a_lift_needs_supply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lift_valve_o != plpc_pkg::VALVE_OFF) |-> (supply_valve_o == plpc_pkg::VALVE_FWD))
    else $error("lift valve driven without supply open");

  // Timer stays within the hold count and its floor of -1
  a_timer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (timer_q <= $signed(TimerW'(ValveHoldTicks))) &&
    (timer_q >= $signed({TimerW{1'b1}})))
    else $error("valve timer out of range");

  // State moves only when a tick runs
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q) && $stable(timer_q))
    else $error("controller state changed without a tick");
`endif

endmodule

`default_nettype wire
